// File: rtl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define SFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/sfp_pkg.sv
// shared constants and the crc byte function of the sensor frame packetizer
package sfp_pkg;

    // frame geometry
    localparam int SAMPLES_PER_FRAME = 5;
    localparam int IMU_WORDS         = 18;
    localparam int ADC_CHANNELS      = 6;
    localparam int ADC_SLOTS         = SAMPLES_PER_FRAME * ADC_CHANNELS;
    localparam int HEADER_WORDS      = 7;
    localparam int FRAME_WORDS       = HEADER_WORDS + ADC_SLOTS + IMU_WORDS + 1;

    // widths, part derived from the frame geometry
    localparam int ADC_W   = 12;
    localparam int WORD_W  = 16;
    localparam int IDX_W   = $clog2(FRAME_WORDS);
    localparam int ADC_AW  = $clog2(ADC_SLOTS);
    localparam int IMU_AW  = $clog2(IMU_WORDS);
    localparam int POS_W   = 3;
    localparam int CFG_IW  = 2;

    // crc-16 settings
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // register reset values
    localparam logic [15:0] SYNC_RESET    = 16'hA55A;
    localparam logic [7:0]  VERSION_RESET = 8'd1;
    localparam logic [7:0]  TYPE_RESET    = 8'd1;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_SYNC_WORD      = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FORMAT_VERSION = 2'd1;
    localparam logic [CFG_IW-1:0] REG_FRAME_TYPE     = 2'd2;

    // header word positions
    localparam logic [IDX_W-1:0] W_SYNC    = IDX_W'(0);
    localparam logic [IDX_W-1:0] W_VERTYPE = IDX_W'(1);
    localparam logic [IDX_W-1:0] W_SEQ     = IDX_W'(2);
    localparam logic [IDX_W-1:0] W_TIME_LO = IDX_W'(3);
    localparam logic [IDX_W-1:0] W_TIME_HI = IDX_W'(4);
    localparam logic [IDX_W-1:0] W_BASE_LO = IDX_W'(5);
    localparam logic [IDX_W-1:0] W_BASE_HI = IDX_W'(6);

    // input item kinds
    localparam logic MODE_ADC = 1'b0;
    localparam logic MODE_IMU = 1'b1;

    // one byte through the msb-first crc-16
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/sensor_frame_packetizer_crc16_unit.sv
// sensor frame packetizer: sample collection, imu cache and crc-16 framed output
//
//   channel  signals                                      transfer when
//   in       in_valid, in_stall, mode .. imu_value        in_valid & !in_stall
//   out      out_valid, out_stall, frame_word, last_word  out_valid & !out_stall
//   cfg      cfg_we, cfg_index, cfg_data                  cfg_we
//
// an imu update or a sample set that does not close a frame is taken without a stall.
// a closing sample set stalls the input while each data word passes through fetch,
// crc low byte, crc high byte and push, and then the crc word is pushed; 56 words
// in all. out_stall holds the sequencer at each push.
// reset clears control state, counters, registers and the imu cache at once.
module sensor_frame_packetizer_crc16_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [31:0]        timestamp_us,
    input  logic [11:0]        adc_ch0,
    input  logic [11:0]        adc_ch1,
    input  logic [11:0]        adc_ch2,
    input  logic [11:0]        adc_ch3,
    input  logic [11:0]        adc_ch4,
    input  logic [11:0]        adc_ch5,
    input  logic [4:0]         imu_index,
    input  logic signed [15:0] imu_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        frame_word,
    output logic               last_word,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    `include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_FETCH    = 3'd1;
    localparam logic [2:0] ST_CRC_LO   = 3'd2;
    localparam logic [2:0] ST_CRC_HI   = 3'd3;
    localparam logic [2:0] ST_PUSH     = 3'd4;
    localparam logic [2:0] ST_PUSH_CRC = 3'd5;

    localparam logic [sfp_pkg::IDX_W-1:0] LAST_DATA_IDX =
        sfp_pkg::IDX_W'(sfp_pkg::FRAME_WORDS - 2);

    logic [2:0]                     state_reg, state_next;
    logic [sfp_pkg::IDX_W-1:0]      word_idx_reg;
    logic [sfp_pkg::WORD_W-1:0]     word_reg;
    logic [15:0]                    crc_reg;
    logic [sfp_pkg::POS_W-1:0]      block_pos_reg;
    logic [31:0]                    start_time_reg;
    logic [31:0]                    base_idx_reg;
    logic [31:0]                    sample_cnt_reg;
    logic [15:0]                    seq_reg;
    logic [15:0]                    sync_reg;
    logic [7:0]                     version_reg;
    logic [7:0]                     type_reg;
    logic [sfp_pkg::ADC_W-1:0]      adc_store_reg [sfp_pkg::ADC_SLOTS];
    logic [sfp_pkg::WORD_W-1:0]     imu_cache_reg [sfp_pkg::IMU_WORDS];
    logic                           out_valid_reg;
    logic [sfp_pkg::WORD_W-1:0]     frame_word_reg;
    logic                           last_word_reg;

    logic                           in_xfer;
    logic                           out_free;
    logic                           adc_item;
    logic                           frame_close;
    logic [sfp_pkg::POS_W-1:0]      pos_eff;
    logic [sfp_pkg::ADC_AW-1:0]     adc_wbase;
    logic [sfp_pkg::ADC_W-1:0]      adc_in [sfp_pkg::ADC_CHANNELS];
    logic [sfp_pkg::ADC_AW-1:0]     adc_raddr;
    logic [sfp_pkg::IMU_AW-1:0]     imu_raddr;
    logic [sfp_pkg::WORD_W-1:0]     word_sel;

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign frame_word = frame_word_reg;
    assign last_word  = last_word_reg;

    // sample set bookkeeping
    assign adc_item    = in_xfer && (mode == sfp_pkg::MODE_ADC);
    assign pos_eff     = (block_pos_reg >= sfp_pkg::POS_W'(sfp_pkg::SAMPLES_PER_FRAME)) ?
                         '0 : block_pos_reg;
    assign frame_close = adc_item &&
                         (pos_eff == sfp_pkg::POS_W'(sfp_pkg::SAMPLES_PER_FRAME - 1));
    assign adc_wbase   = sfp_pkg::ADC_AW'(pos_eff) *
                         sfp_pkg::ADC_AW'(sfp_pkg::ADC_CHANNELS);

    assign adc_in[0] = adc_ch0;
    assign adc_in[1] = adc_ch1;
    assign adc_in[2] = adc_ch2;
    assign adc_in[3] = adc_ch3;
    assign adc_in[4] = adc_ch4;
    assign adc_in[5] = adc_ch5;

    // frame word selection
    assign adc_raddr = sfp_pkg::ADC_AW'(word_idx_reg -
                       sfp_pkg::IDX_W'(sfp_pkg::HEADER_WORDS));
    assign imu_raddr = sfp_pkg::IMU_AW'(word_idx_reg -
                       sfp_pkg::IDX_W'(sfp_pkg::HEADER_WORDS + sfp_pkg::ADC_SLOTS));

    always_comb
    begin
        word_sel = '0;
        if (word_idx_reg < sfp_pkg::IDX_W'(sfp_pkg::HEADER_WORDS))
        begin
            case (word_idx_reg)
                sfp_pkg::W_SYNC:    word_sel = sync_reg;
                sfp_pkg::W_VERTYPE: word_sel = {type_reg, version_reg};
                sfp_pkg::W_SEQ:     word_sel = seq_reg;
                sfp_pkg::W_TIME_LO: word_sel = start_time_reg[15:0];
                sfp_pkg::W_TIME_HI: word_sel = start_time_reg[31:16];
                sfp_pkg::W_BASE_LO: word_sel = base_idx_reg[15:0];
                sfp_pkg::W_BASE_HI: word_sel = base_idx_reg[31:16];
                default:            word_sel = '0;
            endcase
        end
        else if (word_idx_reg <
                 sfp_pkg::IDX_W'(sfp_pkg::HEADER_WORDS + sfp_pkg::ADC_SLOTS))
        begin
            word_sel = sfp_pkg::WORD_W'(adc_store_reg[adc_raddr]);
        end
        else
        begin
            word_sel = imu_cache_reg[imu_raddr];
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (frame_close) state_next = ST_FETCH;
            ST_FETCH:    state_next = ST_CRC_LO;
            ST_CRC_LO:   state_next = ST_CRC_HI;
            ST_CRC_HI:   state_next = ST_PUSH;
            ST_PUSH:
            begin
                if (out_free)
                    state_next = (word_idx_reg == LAST_DATA_IDX) ? ST_PUSH_CRC : ST_FETCH;
            end
            ST_PUSH_CRC: if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control, counters, registers and imu cache
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            word_idx_reg   <= '0;
            block_pos_reg  <= '0;
            start_time_reg <= '0;
            base_idx_reg   <= '0;
            sample_cnt_reg <= '0;
            seq_reg        <= '0;
            sync_reg       <= sfp_pkg::SYNC_RESET;
            version_reg    <= sfp_pkg::VERSION_RESET;
            type_reg       <= sfp_pkg::TYPE_RESET;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < sfp_pkg::IMU_WORDS; i++)
            begin
                imu_cache_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    sfp_pkg::REG_SYNC_WORD:      sync_reg    <= cfg_data;
                    sfp_pkg::REG_FORMAT_VERSION: version_reg <= cfg_data[7:0];
                    sfp_pkg::REG_FRAME_TYPE:     type_reg    <= cfg_data[7:0];
                    default:                     ;
                endcase
            end

            // imu word update, out-of-range index ignored
            if (in_xfer && (mode == sfp_pkg::MODE_IMU) &&
                (imu_index < 5'(sfp_pkg::IMU_WORDS)))
            begin
                imu_cache_reg[imu_index[sfp_pkg::IMU_AW-1:0]] <= imu_value;
            end

            // sample set position and frame header latches
            if (adc_item)
            begin
                if (pos_eff == '0)
                begin
                    start_time_reg <= timestamp_us;
                    base_idx_reg   <= sample_cnt_reg;
                end
                sample_cnt_reg <= sample_cnt_reg + 32'd1;
                block_pos_reg  <= frame_close ? '0 : pos_eff + sfp_pkg::POS_W'(1);
            end

            // word counter
            if (frame_close)
                word_idx_reg <= '0;
            else if ((state_reg == ST_PUSH) && out_free)
                word_idx_reg <= word_idx_reg + sfp_pkg::IDX_W'(1);

            // output register valid
            if (((state_reg == ST_PUSH) || (state_reg == ST_PUSH_CRC)) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            // sequence number steps once the crc word goes out
            if ((state_reg == ST_PUSH_CRC) && out_free)
                seq_reg <= seq_reg + 16'd1;
        end
    end

    // payload: adc store, word holding, crc unit, output data
    always_ff @(posedge clk)
    begin
        if (adc_item)
        begin
            for (int ch = 0; ch < sfp_pkg::ADC_CHANNELS; ch++)
            begin
                adc_store_reg[adc_wbase + sfp_pkg::ADC_AW'(ch)] <= adc_in[ch];
            end
        end

        if (frame_close)
            crc_reg <= sfp_pkg::CRC_INIT;
        else if (state_reg == ST_CRC_LO)
            crc_reg <= sfp_pkg::crc_byte(crc_reg, word_reg[7:0]);
        else if (state_reg == ST_CRC_HI)
            crc_reg <= sfp_pkg::crc_byte(crc_reg, word_reg[15:8]);

        if (state_reg == ST_FETCH)
            word_reg <= word_sel;

        if ((state_reg == ST_PUSH) && out_free)
        begin
            frame_word_reg <= word_reg;
            last_word_reg  <= 1'b0;
        end
        else if ((state_reg == ST_PUSH_CRC) && out_free)
        begin
            frame_word_reg <= crc_reg;
            last_word_reg  <= 1'b1;
        end
    end

    // checks
    `SFP_ASSERT_NOW(a_pos_range, clk, rst_n, 1'b1,
        block_pos_reg < sfp_pkg::POS_W'(sfp_pkg::SAMPLES_PER_FRAME))
    `SFP_ASSERT_NOW(a_idx_range, clk, rst_n, state_reg != ST_IDLE,
        word_idx_reg <= sfp_pkg::IDX_W'(sfp_pkg::FRAME_WORDS - 1))
    `SFP_ASSERT_NEXT(a_crc_last, clk, rst_n, (state_reg == ST_PUSH_CRC) && out_free,
        out_valid && last_word && (state_reg == ST_IDLE))

endmodule
